// ===== hdl/tti_pkg.sv =====
// shared types, constants and helpers for the thermistor table interpolator
package tti_pkg;

  // payload field widths
  localparam int TEMP_W     = 24;
  localparam int IDX_IN_W   = 8;
  localparam int RES_IN_W   = 24;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // quotient bits kept by the divider; larger offsets saturate the result anyway
  localparam int QUO_W  = 26;
  // whole-degree grid temperature, its Q.8 form and the final sum
  localparam int GRID_W = 18;
  localparam int FIX_W  = GRID_W + 8;
  localparam int SUM_W  = FIX_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

  // request kinds
  localparam logic REQ_CONVERT = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  // temperature limits and out-of-range code (-1.0 in Q15.8)
  localparam logic signed [TEMP_W-1:0] TEMP_OOR = -24'sd256;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7FFFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;

  // conversion sequencer states
  typedef enum logic [11:0] {
    ST_IDLE  = 12'h001,
    ST_RD_LO = 12'h002,
    ST_RD_HI = 12'h004,
    ST_CHK   = 12'h008,
    ST_SRCH  = 12'h010,
    ST_CMP   = 12'h020,
    ST_RD_Y1 = 12'h040,
    ST_MUL   = 12'h080,
    ST_NUM   = 12'h100,
    ST_DIV   = 12'h200,
    ST_GRID  = 12'h400,
    ST_OUT   = 12'h800
  } state_t;

  // clamp a wide signed temperature into the output range
  function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [SUM_W-1:0] v);
    logic [TEMP_W-1:0] res;
    if (v > SUM_W'(TEMP_MAX)) begin
      res = TEMP_MAX;
    end else if (v < SUM_W'(TEMP_MIN)) begin
      res = TEMP_MIN;
    end else begin
      res = v[TEMP_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/tti_table_ram.sv =====
// resistance table memory, one write port and one registered read port
module tti_table_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tti_divider.sv =====
// restoring divider, one quotient bit per cycle, saturating quotient
module tti_divider
  import tti_pkg::*;
#(
  parameter int DVD_W = 42,
  parameter int DVS_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic             load_r, load_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;

  logic             ovf;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  // quotient would not fit: upper dividend part already reaches the divisor
  assign ovf = DVD_W'(dvd_r[DVD_W-1:QUO_W]) >= DVD_W'(dvs_r);

  // one restoring step
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    load_nxt = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      load_nxt = 1'b1;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (load_r) begin
      if (ovf) begin
        quo_nxt  = '1;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = DVS_W'(dvd_r[DVD_W-1:QUO_W]);
        quo_nxt = dvd_r[QUO_W-1:0];
        cnt_nxt = CNT_W'(QUO_W);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      load_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      load_r <= load_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/thermistor_table_interpolator.sv =====
// thermistor table interpolator: table write, binary search, linear interpolation
// a table write is taken in the idle state and gives no result
// a convert out of table range passes ST_RD_LO, ST_RD_HI, ST_CHK and ST_OUT before its result
// an in-range convert passes ST_SRCH and ST_CMP with one table read per search step
// (up to 9 steps for 256 entries), plus the 26-step divider for the interpolation offset
// synchronous reset clears control and config; table contents stay undefined until written
module thermistor_table_interpolator
  import tti_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int RES_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [7:0] entry_index, [31:8] resistance
  input  logic                  in_tuser,   // [0] req_type
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TEMP_W-1:0]     out_tdata,  // [23:0] temperature
  output logic                  out_tuser,  // [0] in_range
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DIFF_W = RES_BITS + 1;
  localparam int PROD_W = RES_BITS + 10;
  localparam int DVD_W  = RES_BITS + 18;
  localparam int DVS_W  = RES_BITS + 1;

  // configuration registers
  logic [CFG_DATA_W-1:0] entries_r;
  logic signed [7:0]     start_r;
  logic [7:0]            step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= 9'd256;
      start_r   <= 8'sd0;
      step_r    <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRIES: entries_r <= cfg_data;
        CFG_START:   start_r   <= $signed(cfg_data[7:0]);
        CFG_STEP:    step_r    <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // entry count clamped to the table
  logic [CNT_W-1:0] n_sat;
  logic [IDX_W-1:0] maxi;

  always_comb begin
    if (entries_r < 9'd2) begin
      n_sat = CNT_W'(2);
    end else if (entries_r > 9'(TABLE_DEPTH)) begin
      n_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      n_sat = CNT_W'(entries_r);
    end
  end

  assign maxi = IDX_W'(n_sat - CNT_W'(1));

  // input fields
  logic [RES_BITS-1:0] in_res;
  logic [IDX_IN_W-1:0] in_idx;
  logic                in_xfer;

  assign in_idx  = in_tdata[IDX_IN_W-1:0];
  assign in_res  = RES_BITS'(in_tdata[IDX_IN_W +: RES_IN_W]);
  assign in_xfer = in_tvalid && in_tready;

  // table memory
  logic                ram_we;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [RES_BITS-1:0] ram_rdata;

  assign ram_we = in_xfer && (in_tuser == REQ_WRITE) &&
                  ({1'b0, in_idx} < 9'(TABLE_DEPTH));

  tti_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (RES_BITS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx[IDX_W-1:0]),
    .wdata (in_res),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and datapath registers
  state_t                     state_r, state_nxt;
  logic [RES_BITS-1:0]        res_r, res_nxt;
  logic [RES_BITS-1:0]        t0_r, t0_nxt;
  logic [CNT_W-1:0]           lo_r, lo_nxt;
  logic [CNT_W-1:0]           hip1_r, hip1_nxt;
  logic [IDX_W-1:0]           mid_r, mid_nxt;
  logic [IDX_W-1:0]           i_r, i_nxt;
  logic [RES_BITS-1:0]        y2_r, y2_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [DIFF_W-1:0]   den_r, den_nxt;
  logic [IDX_W-1:0]           grid_idx_r, grid_idx_nxt;
  logic                       inr_r, inr_nxt;
  logic [TEMP_W-1:0]          temp_r, temp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]          out_temp_r, out_temp_nxt;
  logic                       out_inr_r, out_inr_nxt;

  // search helpers
  logic [CNT_W:0]             mid_sum;
  logic [IDX_W-1:0]           mid_calc;
  logic [IDX_W-1:0]           idx_found;

  assign mid_sum   = (CNT_W+1)'(lo_r) + (CNT_W+1)'(hip1_r) - (CNT_W+1)'(1);
  assign mid_calc  = mid_sum[IDX_W:1];
  assign idx_found = (hip1_r == '0) ? '0 : IDX_W'(hip1_r - CNT_W'(1));

  // interpolation numerator and denominator
  logic signed [DIFF_W-1:0]   den_c;
  logic signed [DIFF_W-1:0]   diff_c;
  logic signed [PROD_W-1:0]   prod_c;

  assign den_c  = $signed({1'b0, y2_r}) - $signed({1'b0, ram_rdata});
  assign diff_c = $signed({1'b0, res_r}) - $signed({1'b0, ram_rdata});
  assign prod_c = diff_c * $signed({1'b0, step_r});

  // divider operands: floor((2|num| + |den|) / (2|den|)) rounds half away from zero
  logic [PROD_W-1:0]          prod_abs;
  logic [DIFF_W-1:0]          den_abs;
  logic [DVD_W-1:0]           div_dividend;
  logic [DVS_W-1:0]           div_divisor;
  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [QUO_W-1:0]           div_quo;
  logic                       div_neg;

  assign prod_abs     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign den_abs      = den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
  assign div_dividend = (DVD_W'(prod_abs) << 9) + DVD_W'(den_abs);
  assign div_divisor  = {den_abs[RES_BITS-1:0], 1'b0};
  assign div_neg      = prod_r[PROD_W-1] ^ den_r[DIFF_W-1];

  tti_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // grid temperature of the selected entry, then the final sum
  logic [IDX_W+7:0]           grid_prod;
  logic signed [GRID_W-1:0]   grid_c;
  logic signed [SUM_W-1:0]    fix_grid;
  logic signed [QUO_W:0]      off_s;
  logic signed [SUM_W-1:0]    interp_sum;

  assign grid_prod  = (IDX_W+8)'(grid_idx_r) * (IDX_W+8)'(step_r);
  assign grid_c     = GRID_W'(start_r) + $signed(GRID_W'(grid_prod));
  assign fix_grid   = SUM_W'(grid_c) <<< 8;
  assign off_s      = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign interp_sum = fix_grid - SUM_W'(off_s);

  // conversion sequencer
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    t0_nxt        = t0_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    mid_nxt       = mid_r;
    i_nxt         = i_r;
    y2_nxt        = y2_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    grid_idx_nxt  = grid_idx_r;
    inr_nxt       = inr_r;
    temp_nxt      = temp_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_temp_nxt  = out_temp_r;
    out_inr_nxt   = out_inr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_tuser == REQ_CONVERT)) begin
          res_nxt   = in_res;
          state_nxt = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        ram_re    = 1'b1;
        ram_raddr = maxi;
        t0_nxt    = ram_rdata;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if ((res_r <= t0_r) && (res_r >= ram_rdata)) begin
          inr_nxt   = 1'b1;
          lo_nxt    = '0;
          hip1_nxt  = n_sat;
          state_nxt = ST_SRCH;
        end else begin
          inr_nxt   = 1'b0;
          temp_nxt  = TEMP_OOR;
          state_nxt = ST_OUT;
        end
      end
      ST_SRCH: begin
        if (lo_r < hip1_r) begin
          ram_re    = 1'b1;
          ram_raddr = mid_calc;
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end else begin
          i_nxt = idx_found;
          if (idx_found >= maxi) begin
            // last entry returns its grid temperature
            grid_idx_nxt = maxi;
            state_nxt    = ST_GRID;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_found;
            state_nxt = ST_RD_Y1;
          end
        end
      end
      ST_CMP: begin
        if (res_r > ram_rdata) begin
          hip1_nxt = CNT_W'(mid_r);
        end else begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end
        state_nxt = ST_SRCH;
      end
      ST_RD_Y1: begin
        ram_re    = 1'b1;
        ram_raddr = i_r + IDX_W'(1);
        y2_nxt    = ram_rdata;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (den_c == '0) begin
          // equal neighbors: grid temperature of the found entry
          grid_idx_nxt = i_r;
          state_nxt    = ST_GRID;
        end else begin
          prod_nxt     = prod_c;
          den_nxt      = den_c;
          grid_idx_nxt = i_r + IDX_W'(1);
          state_nxt    = ST_NUM;
        end
      end
      ST_NUM: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          temp_nxt  = sat_temp(interp_sum);
          state_nxt = ST_OUT;
        end
      end
      ST_GRID: begin
        temp_nxt  = sat_temp(fix_grid);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_r;
          out_inr_nxt   = inr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    t0_r       <= t0_nxt;
    lo_r       <= lo_nxt;
    hip1_r     <= hip1_nxt;
    mid_r      <= mid_nxt;
    i_r        <= i_nxt;
    y2_r       <= y2_nxt;
    prod_r     <= prod_nxt;
    den_r      <= den_nxt;
    grid_idx_r <= grid_idx_nxt;
    inr_r      <= inr_nxt;
    temp_r     <= temp_nxt;
    out_temp_r <= out_temp_nxt;
    out_inr_r  <= out_inr_nxt;
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_temp_r;
  assign out_tuser  = out_inr_r;

  // table writes only happen while no lookup read is in flight
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("table write overlaps a lookup read");

  // search window never inverts
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (lo_r <= hip1_r))
    else $error("binary search window inverted");

  // divider is started only when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // out-of-range results carry the fixed code
  a_oor_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == TEMP_OOR))
    else $error("out-of-range result with wrong temperature");

  // a convert transfer starts the table lookup
  a_convert_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == REQ_CONVERT)) |=> (state_r == ST_RD_LO))
    else $error("convert transfer did not start a lookup");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the thermistor table interpolator
`timescale 1ns / 1ps
module testbench;
  import tti_pkg::*;

  localparam int DEPTH          = 256;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 13;
  localparam int HEAD_ENTRIES   = 8;
  // no register sits at this index, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              in_range;
  } temp_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // [7:0] entry_index, [31:8] resistance
  logic                  in_tuser;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TEMP_W-1:0]     out_tdata;  // [23:0] temperature
  logic                  out_tuser;  // [0] in_range
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the block: table contents and register settings
  logic [RES_IN_W-1:0] res_table [DEPTH];
  int cfg_entries;
  int cfg_start;
  int cfg_step;

  temp_result_t pending_temps[$];
  temp_result_t want;
  int fail_count     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  thermistor_table_interpolator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side ready: long hold-off when requested, random stalls otherwise
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_temps.size() == 0) begin
        $error("unexpected result: temperature %0d in_range %0b", $signed(out_tdata), out_tuser);
        fail_count++;
      end else begin
        want = pending_temps.pop_front();
        if (out_tdata !== want.temperature) begin
          $error("temperature: expected %0d, got %0d",
                 $signed(want.temperature), $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // entry count as the block uses it
  function automatic int active_entries();
    if (cfg_entries < 2) begin
      return 2;
    end
    if (cfg_entries > DEPTH) begin
      return DEPTH;
    end
    return cfg_entries;
  endfunction

  // grid temperature of an entry in Q.8
  function automatic longint grid_q8(int pos);
    return longint'(cfg_start + pos * cfg_step) * 256;
  endfunction

  // search the table and interpolate toward the next entry
  function automatic temp_result_t predict_temperature(logic [RES_IN_W-1:0] r);
    temp_result_t res;
    int n, lo, hi, mid, pos;
    longint y2, y1, den, num, mag_num, mag_den, quo, t;
    n = active_entries();
    res.temperature = TEMP_OOR;
    res.in_range = 1'b0;
    if (r <= res_table[0] && r >= res_table[n-1]) begin
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (r > res_table[mid]) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      pos = (hi < 0) ? 0 : hi;
      if (pos >= n - 1) begin
        // last entry returns its grid point exactly
        t = grid_q8(n - 1);
      end else begin
        y2 = longint'(res_table[pos]);
        y1 = longint'(res_table[pos+1]);
        den = y2 - y1;
        if (den == 0) begin
          t = grid_q8(pos);
        end else begin
          // rounded to nearest, halves away from zero
          num = (longint'(r) - y1) * cfg_step * 256;
          mag_num = (num < 0) ? -num : num;
          mag_den = (den < 0) ? -den : den;
          quo = (2 * mag_num + mag_den) / (2 * mag_den);
          if ((num < 0) != (den < 0)) begin
            quo = -quo;
          end
          t = grid_q8(pos + 1) - quo;
        end
      end
      if (t > longint'(TEMP_MAX)) begin
        t = longint'(TEMP_MAX);
      end
      if (t < longint'(TEMP_MIN)) begin
        t = longint'(TEMP_MIN);
      end
      res.temperature = t[TEMP_W-1:0];
      res.in_range = 1'b1;
    end
    return res;
  endfunction

  // random resistance between the first and last active entries
  function automatic logic [RES_IN_W-1:0] pick_in_range();
    return RES_IN_W'($urandom_range(res_table[0], res_table[active_entries()-1]));
  endfunction

  // offer one item, wait for its transfer, then update the shadow
  task automatic send_request(logic req, logic [IDX_IN_W-1:0] idx, logic [RES_IN_W-1:0] res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {res, idx};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    if (req == REQ_WRITE) begin
      res_table[idx] = res;
    end else begin
      pending_temps.push_back(predict_temperature(res));
    end
  endtask

  task automatic convert(logic [RES_IN_W-1:0] r);
    send_request(REQ_CONVERT, IDX_IN_W'($urandom), r);
  endtask

  // one register write; the caller lowers cfg_valid after a group
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_ENTRIES: cfg_entries = val;
      CFG_START:   cfg_start = $signed(val[7:0]);
      CFG_STEP:    cfg_step = val[7:0];
      default: ;
    endcase
  endtask

  // all registers, spare top bits random, plus a write to the unused index
  task automatic set_config(int entries, int start, int step);
    write_reg(CFG_ENTRIES, entries[CFG_DATA_W-1:0]);
    write_reg(CFG_START, {1'($urandom_range(1)), start[7:0]});
    write_reg(CFG_STEP, {1'($urandom_range(1)), step[7:0]});
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let all results drain and the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_temps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // rewrite entries from zero as a falling curve that stays above the next entry
  task automatic load_profile(int count);
    longint floor_val, level, drop_max;
    floor_val = (count < DEPTH) ? longint'(res_table[count]) : 0;
    level = $urandom_range(24'hFFFFFF, floor_val);
    drop_max = (level - floor_val) / count;
    for (int k = 0; k < count; k++) begin
      send_request(REQ_WRITE, k[IDX_IN_W-1:0], level[RES_IN_W-1:0]);
      level = level - $urandom_range(drop_max);
    end
  endtask

  // full table load, then the reset settings at both ends, outside the range and at a random point inside
  task automatic test_reset_config();
    load_profile(DEPTH);
    convert(res_table[0]);
    convert(res_table[DEPTH-1]);
    convert(res_table[0] + 1'b1);
    convert(res_table[DEPTH-1] - 1'b1);
    convert(24'hFFFFFF);
    convert(24'h000000);
    convert(pick_in_range());
  endtask

  // entry counts below two and above the table size saturate
  task automatic test_entry_limits();
    wait_idle();
    set_config(0, 10, 3);
    convert(res_table[1]);
    convert(pick_in_range());
    convert(res_table[0]);
    wait_idle();
    set_config(511, -5, 7);
    convert(res_table[DEPTH-1]);
    convert(pick_in_range());
  endtask

  // two neighbors holding the same resistance
  task automatic test_equal_neighbors();
    wait_idle();
    set_config(4, 20, 10);
    send_request(REQ_WRITE, 8'd2, res_table[1]);
    convert(res_table[1]);
    convert(RES_IN_W'($urandom_range(res_table[0], res_table[1])));
  endtask

  // a middle entry above its neighbors
  task automatic test_non_monotone();
    send_request(REQ_WRITE, 8'd2, res_table[0]);
    convert(pick_in_range());
    convert(res_table[3]);
  endtask

  // grid temperatures beyond the output range saturate
  task automatic test_overflow();
    wait_idle();
    set_config(256, 127, 255);
    convert(res_table[DEPTH-1]);
    convert(pick_in_range());
    convert(res_table[0]);
  endtask

  // result side held off while items keep coming
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (20) begin
      convert(pick_in_range());
    end
  endtask

  // phases of settings and idling, mostly well-formed table updates and converts
  task automatic test_random_traffic();
    int entries, start, step, n, pick, k;
    logic [RES_IN_W-1:0] lo_val, hi_val, r;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      entries = $urandom_range(3, 255);
      start = $urandom_range(255);
      step = $urandom_range(255);
      case (p)
        0: begin
          entries = 2;
          start = -128;
          step = 255;
        end
        1: begin
          entries = 256;
          start = 127;
          step = 0;
        end
        2: entries = 0;
        3: begin
          entries = 511;
          step = 255;
        end
        4: entries = 1;
        5: entries = $urandom_range(257, 511);
        default: ;
      endcase
      set_config(entries, start, step);
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 70;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 70;
        end
        default: begin
          src_idle_pct = 31;
          sink_stall_pct = 31;
        end
      endcase
      n = active_entries();
      load_profile((n < HEAD_ENTRIES) ? n : HEAD_ENTRIES);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          // entry rewritten between its neighbors
          k = $urandom_range(n - 1);
          lo_val = (k == DEPTH - 1) ? '0 : res_table[k+1];
          hi_val = (k == 0) ? 24'hFFFFFF : res_table[k-1];
          send_request(REQ_WRITE, k[IDX_IN_W-1:0], RES_IN_W'($urandom_range(hi_val, lo_val)));
        end else if (pick < 20) begin
          // arbitrary entry, arbitrary value
          send_request(REQ_WRITE, IDX_IN_W'($urandom), RES_IN_W'($urandom));
        end else begin
          lo_val = res_table[n-1];
          hi_val = res_table[0];
          pick = $urandom_range(99);
          if (pick < 70) begin
            r = RES_IN_W'($urandom_range(hi_val, lo_val));
          end else if (pick < 80) begin
            r = res_table[$urandom_range(n - 1)];
          end else if (pick < 85) begin
            r = hi_val + 1'b1;
          end else if (pick < 90) begin
            r = lo_val - 1'b1;
          end else begin
            r = RES_IN_W'($urandom);
          end
          convert(r);
        end
      end
    end
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_CONVERT;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ENTRIES;
    cfg_data    = '0;
    cfg_entries = DEPTH;
    cfg_start   = 0;
    cfg_step    = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_entry_limits();
    test_equal_neighbors();
    test_non_monotone();
    test_overflow();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
